// File: rtl/ckey_pkg.sv
package ckey_pkg;

	localparam int CH_W       = 8;
	localparam int Q16_W      = 17;
	localparam int SQ_W       = 18;
	localparam int SQV_W      = 34;
	localparam int ROOT_W     = 17;
	localparam int REM_W      = 19;
	localparam int DIST_W     = 16;
	localparam int T_W        = 16;
	localparam int W_W        = 18;
	localparam int S_W        = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int SQRT_STEPS = 17;
	localparam int DIV_STEPS  = 16;

	localparam int PIPE_DEPTH = 2 + SQRT_STEPS + 2 + DIV_STEPS + 3;

	localparam logic [DIST_W-1:0] NORM_SCALE = 16'd37985;
	localparam logic [W_W-1:0]    SMOOTH_K   = 18'd196608;
	localparam logic [15:0]       ROUND_HALF = 16'd32768;
	localparam logic [CH_W-1:0]   CH_MAX     = 8'd255;

	localparam logic [CH_W-1:0]  KEY_RED_RST   = 8'd0;
	localparam logic [CH_W-1:0]  KEY_GREEN_RST = 8'd255;
	localparam logic [CH_W-1:0]  KEY_BLUE_RST  = 8'd0;
	localparam logic [Q16_W-1:0] THRESH_RST    = 17'd19661;
	localparam logic [Q16_W-1:0] SOFT_RST      = 17'd6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_RED   = 3'd0,
		REG_KEY_GREEN = 3'd1,
		REG_KEY_BLUE  = 3'd2,
		REG_THRESH    = 3'd3,
		REG_SOFT      = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_CUT  = 2'd1,
		MODE_RAMP = 2'd2
	} mode_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} pix_t;

endpackage

// File: rtl/chroma_key_alpha_unit.sv
// channel   direction  handshake              payload
// command   in         start, busy            in_red, in_green, in_blue, in_alpha
// result    out        done (one-cycle)       out_red, out_green, out_blue, out_alpha
// config    in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// one pixel per clock, busy stays low and cfg_ready stays high
// a result passes through 2 distance stages, 17 square-root
// steps, scale and compare, 16 divider steps, 3 smoothstep and alpha stages
// asynchronous reset clears all valid bits and loads the register defaults
// the receiver cannot stall, so the pipeline advances every cycle
module chroma_key_alpha_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ckey_pkg::CH_W-1:0]        in_red,
	input  logic [ckey_pkg::CH_W-1:0]        in_green,
	input  logic [ckey_pkg::CH_W-1:0]        in_blue,
	input  logic [ckey_pkg::CH_W-1:0]        in_alpha,
	output logic                             done,
	output logic [ckey_pkg::CH_W-1:0]        out_red,
	output logic [ckey_pkg::CH_W-1:0]        out_green,
	output logic [ckey_pkg::CH_W-1:0]        out_blue,
	output logic [ckey_pkg::CH_W-1:0]        out_alpha,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ckey_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ckey_pkg::Q16_W-1:0]       cfg_data
);

	localparam int SQN = ckey_pkg::SQRT_STEPS;
	localparam int DVN = ckey_pkg::DIV_STEPS;

	// configuration registers
	logic [ckey_pkg::CH_W-1:0]  key_red_q;
	logic [ckey_pkg::CH_W-1:0]  key_green_q;
	logic [ckey_pkg::CH_W-1:0]  key_blue_q;
	logic [ckey_pkg::Q16_W-1:0] thresh_q;
	logic [ckey_pkg::Q16_W-1:0] soft_q;

	// stage 1 and 2
	logic                        vld_s1;
	ckey_pkg::pix_t              pix_s1;
	logic [2*ckey_pkg::CH_W-1:0] sqr_s1;
	logic [2*ckey_pkg::CH_W-1:0] sqg_s1;
	logic [2*ckey_pkg::CH_W-1:0] sqb_s1;
	logic [ckey_pkg::CH_W-1:0]   dr;
	logic [ckey_pkg::CH_W-1:0]   dg;
	logic [ckey_pkg::CH_W-1:0]   db;
	logic [ckey_pkg::SQ_W-1:0]   sq_sum;

	// square root pipe, index 0 is stage 2
	logic                          rt_vld_s  [0:SQN];
	ckey_pkg::pix_t                rt_pix_s  [0:SQN];
	logic [ckey_pkg::SQV_W-1:0]    rt_v_s    [0:SQN];
	logic [ckey_pkg::REM_W-1:0]    rt_rem_s  [0:SQN];
	logic [ckey_pkg::ROOT_W-1:0]   rt_root_s [0:SQN];
	logic [ckey_pkg::REM_W+1:0]    rt_sh     [1:SQN];
	logic [ckey_pkg::REM_W+1:0]    rt_trial  [1:SQN];
	logic [ckey_pkg::REM_W+1:0]    rt_diff   [1:SQN];
	logic                          rt_ge     [1:SQN];

	// scaled distance
	logic                                     vld_s20;
	ckey_pkg::pix_t                           pix_s20;
	logic [ckey_pkg::DIST_W-1:0]              dist_s20;
	logic [ckey_pkg::ROOT_W+ckey_pkg::DIST_W-1:0] d_prod;

	// compare and divider pipe, index 0 is the compare stage
	logic                          dv_vld_s  [0:DVN];
	ckey_pkg::pix_t                dv_pix_s  [0:DVN];
	ckey_pkg::mode_t               dv_mode_s [0:DVN];
	logic [ckey_pkg::Q16_W-1:0]    dv_rem_s  [0:DVN];
	logic [ckey_pkg::T_W-1:0]      dv_q_s    [0:DVN];
	logic [ckey_pkg::Q16_W:0]      dv_sh     [1:DVN];
	logic [ckey_pkg::Q16_W:0]      dv_diff   [1:DVN];
	logic                          dv_ge     [1:DVN];
	logic [ckey_pkg::Q16_W:0]      thr_end;
	logic [ckey_pkg::Q16_W-1:0]    d_ext;
	logic [ckey_pkg::Q16_W-1:0]    d_minus;
	ckey_pkg::mode_t               mode_cmp;

	// smoothstep and alpha
	logic                          vld_s38;
	ckey_pkg::pix_t                pix_s38;
	ckey_pkg::mode_t               mode_s38;
	logic [2*ckey_pkg::T_W-1:0]    tt_s38;
	logic [ckey_pkg::W_W-1:0]      w_s38;
	logic [2*ckey_pkg::T_W-1:0]    t_sqr;
	logic                          vld_s39;
	ckey_pkg::pix_t                pix_s39;
	ckey_pkg::mode_t               mode_s39;
	logic [ckey_pkg::S_W-1:0]      smo_s39;
	logic [2*ckey_pkg::T_W+ckey_pkg::W_W-1:0] s_prod;
	logic                          vld_s40;
	ckey_pkg::pix_t                pix_s40;
	logic [ckey_pkg::CH_W+ckey_pkg::S_W-1:0]  a_prod;
	logic [ckey_pkg::CH_W:0]       a_scaled;
	logic [ckey_pkg::CH_W-1:0]     a_ramp;
	logic [ckey_pkg::CH_W-1:0]     a_next;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_red_q   <= ckey_pkg::KEY_RED_RST;
			key_green_q <= ckey_pkg::KEY_GREEN_RST;
			key_blue_q  <= ckey_pkg::KEY_BLUE_RST;
			thresh_q    <= ckey_pkg::THRESH_RST;
			soft_q      <= ckey_pkg::SOFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ckey_pkg::REG_KEY_RED: begin
					key_red_q <= cfg_data[ckey_pkg::CH_W-1:0];
				end
				ckey_pkg::REG_KEY_GREEN: begin
					key_green_q <= cfg_data[ckey_pkg::CH_W-1:0];
				end
				ckey_pkg::REG_KEY_BLUE: begin
					key_blue_q <= cfg_data[ckey_pkg::CH_W-1:0];
				end
				ckey_pkg::REG_THRESH: begin
					thresh_q <= cfg_data;
				end
				ckey_pkg::REG_SOFT: begin
					soft_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// absolute channel differences
	assign dr = (in_red > key_red_q) ? in_red - key_red_q : key_red_q - in_red;
	assign dg = (in_green > key_green_q) ? in_green - key_green_q : key_green_q - in_green;
	assign db = (in_blue > key_blue_q) ? in_blue - key_blue_q : key_blue_q - in_blue;

	assign sq_sum = {2'b00, sqr_s1} + {2'b00, sqg_s1} + {2'b00, sqb_s1};

	// one root bit per stage
	always_comb begin
		for (int k = 1; k <= SQN; k++) begin
			rt_sh[k]    = {rt_rem_s[k-1], rt_v_s[k-1][ckey_pkg::SQV_W-1 -: 2]};
			rt_trial[k] = {2'b00, rt_root_s[k-1], 2'b01};
			rt_ge[k]    = rt_sh[k] >= rt_trial[k];
			rt_diff[k]  = rt_sh[k] - rt_trial[k];
		end
	end

	assign d_prod = {{ckey_pkg::DIST_W{1'b0}}, rt_root_s[SQN]}
		* {{ckey_pkg::ROOT_W{1'b0}}, ckey_pkg::NORM_SCALE};

	// cut and ramp decision
	assign d_ext   = {1'b0, dist_s20};
	assign thr_end = {1'b0, thresh_q} + {1'b0, soft_q};
	assign d_minus = d_ext - thresh_q;

	always_comb begin
		if (d_ext < thresh_q) begin
			mode_cmp = ckey_pkg::MODE_CUT;
		end else if ((soft_q != '0) && ({1'b0, d_ext} < thr_end)) begin
			mode_cmp = ckey_pkg::MODE_RAMP;
		end else begin
			mode_cmp = ckey_pkg::MODE_PASS;
		end
	end

	// one quotient bit per stage
	always_comb begin
		for (int k = 1; k <= DVN; k++) begin
			dv_sh[k]   = {dv_rem_s[k-1], 1'b0};
			dv_ge[k]   = dv_sh[k] >= {1'b0, soft_q};
			dv_diff[k] = dv_sh[k] - {1'b0, soft_q};
		end
	end

	assign t_sqr  = {{ckey_pkg::T_W{1'b0}}, dv_q_s[DVN]} * {{ckey_pkg::T_W{1'b0}}, dv_q_s[DVN]};
	assign s_prod = {{ckey_pkg::W_W{1'b0}}, tt_s38} * {{2*ckey_pkg::T_W{1'b0}}, w_s38};

	assign a_prod   = {{ckey_pkg::S_W{1'b0}}, pix_s39.alpha}
		* {{ckey_pkg::CH_W{1'b0}}, smo_s39}
		+ {{(ckey_pkg::CH_W+ckey_pkg::S_W-16){1'b0}}, ckey_pkg::ROUND_HALF};
	assign a_scaled = a_prod[16 +: ckey_pkg::CH_W+1];
	assign a_ramp   = a_scaled[ckey_pkg::CH_W] ? ckey_pkg::CH_MAX : a_scaled[ckey_pkg::CH_W-1:0];

	always_comb begin
		case (mode_s39)
			ckey_pkg::MODE_CUT: begin
				a_next = '0;
			end
			ckey_pkg::MODE_RAMP: begin
				a_next = a_ramp;
			end
			default: begin
				a_next = pix_s39.alpha;
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s20 <= 1'b0;
			vld_s38 <= 1'b0;
			vld_s39 <= 1'b0;
			vld_s40 <= 1'b0;
			for (int k = 0; k <= SQN; k++) begin
				rt_vld_s[k] <= 1'b0;
			end
			for (int k = 0; k <= DVN; k++) begin
				dv_vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s1      <= start && !busy;
			rt_vld_s[0] <= vld_s1;
			for (int k = 1; k <= SQN; k++) begin
				rt_vld_s[k] <= rt_vld_s[k-1];
			end
			vld_s20     <= rt_vld_s[SQN];
			dv_vld_s[0] <= vld_s20;
			for (int k = 1; k <= DVN; k++) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
			vld_s38 <= dv_vld_s[DVN];
			vld_s39 <= vld_s38;
			vld_s40 <= vld_s39;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		pix_s1 <= '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};
		sqr_s1 <= {{ckey_pkg::CH_W{1'b0}}, dr} * {{ckey_pkg::CH_W{1'b0}}, dr};
		sqg_s1 <= {{ckey_pkg::CH_W{1'b0}}, dg} * {{ckey_pkg::CH_W{1'b0}}, dg};
		sqb_s1 <= {{ckey_pkg::CH_W{1'b0}}, db} * {{ckey_pkg::CH_W{1'b0}}, db};

		rt_pix_s[0]  <= pix_s1;
		rt_v_s[0]    <= {sq_sum, {(ckey_pkg::SQV_W-ckey_pkg::SQ_W){1'b0}}};
		rt_rem_s[0]  <= '0;
		rt_root_s[0] <= '0;
		for (int k = 1; k <= SQN; k++) begin
			rt_pix_s[k] <= rt_pix_s[k-1];
			rt_v_s[k]   <= {rt_v_s[k-1][ckey_pkg::SQV_W-3:0], 2'b00};
			if (rt_ge[k]) begin
				rt_rem_s[k]  <= rt_diff[k][ckey_pkg::REM_W-1:0];
				rt_root_s[k] <= {rt_root_s[k-1][ckey_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rt_rem_s[k]  <= rt_sh[k][ckey_pkg::REM_W-1:0];
				rt_root_s[k] <= {rt_root_s[k-1][ckey_pkg::ROOT_W-2:0], 1'b0};
			end
		end

		pix_s20  <= rt_pix_s[SQN];
		dist_s20 <= d_prod[ckey_pkg::DIST_W +: ckey_pkg::DIST_W];

		dv_pix_s[0]  <= pix_s20;
		dv_mode_s[0] <= mode_cmp;
		dv_rem_s[0]  <= d_minus;
		dv_q_s[0]    <= '0;
		for (int k = 1; k <= DVN; k++) begin
			dv_pix_s[k]  <= dv_pix_s[k-1];
			dv_mode_s[k] <= dv_mode_s[k-1];
			if (dv_ge[k]) begin
				dv_rem_s[k] <= dv_diff[k][ckey_pkg::Q16_W-1:0];
				dv_q_s[k]   <= {dv_q_s[k-1][ckey_pkg::T_W-2:0], 1'b1};
			end else begin
				dv_rem_s[k] <= dv_sh[k][ckey_pkg::Q16_W-1:0];
				dv_q_s[k]   <= {dv_q_s[k-1][ckey_pkg::T_W-2:0], 1'b0};
			end
		end

		pix_s38  <= dv_pix_s[DVN];
		mode_s38 <= dv_mode_s[DVN];
		tt_s38   <= t_sqr;
		w_s38    <= ckey_pkg::SMOOTH_K - {1'b0, dv_q_s[DVN], 1'b0};

		pix_s39  <= pix_s38;
		mode_s39 <= mode_s38;
		smo_s39  <= s_prod[2*ckey_pkg::T_W +: ckey_pkg::S_W];

		pix_s40 <= '{red: pix_s39.red, green: pix_s39.green, blue: pix_s39.blue,
			alpha: a_next};
	end

	assign done      = vld_s40;
	assign out_red   = pix_s40.red;
	assign out_green = pix_s40.green;
	assign out_blue  = pix_s40.blue;
	assign out_alpha = pix_s40.alpha;

endmodule

// File: rtl/ckey_checker.sv
module ckey_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [ckey_pkg::CH_W-1:0] in_red,
	input logic [ckey_pkg::CH_W-1:0] in_green,
	input logic [ckey_pkg::CH_W-1:0] in_blue,
	input logic [ckey_pkg::CH_W-1:0] in_alpha,
	input logic                      done,
	input logic [ckey_pkg::CH_W-1:0] out_red,
	input logic [ckey_pkg::CH_W-1:0] out_green,
	input logic [ckey_pkg::CH_W-1:0] out_blue,
	input logic [ckey_pkg::CH_W-1:0] out_alpha
);

	localparam int LAT   = ckey_pkg::PIPE_DEPTH;
	localparam int WRM_W = $clog2(LAT + 1);

	logic [WRM_W-1:0] warm_q;
	logic             warm;

	// cycles since reset, saturating at the pipeline depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (!warm) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	assign warm = warm_q == WRM_W'(LAT);

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done |-> $past(start && !busy, LAT))
		else $error("result word without a command");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		warm && $past(start && !busy, LAT) |-> done)
		else $error("command word lost");

	a_rgb_pass: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done |-> out_red == $past(in_red, LAT) && out_green == $past(in_green, LAT)
			&& out_blue == $past(in_blue, LAT))
		else $error("color channels altered");

	a_alpha_bound: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done |-> out_alpha <= $past(in_alpha, LAT))
		else $error("keyed alpha above input alpha");

endmodule

bind chroma_key_alpha_unit ckey_checker u_ckey_checker (.*);
